[rtl/size_class_free_list_allocator_core_defines.svh]
// ============================================================================
// size_class_free_list_allocator_core_defines: assertion macros
// Shorthand for the clocked, reset-qualified checks used in the allocator RTL.
// ============================================================================
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define SCFLA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define SCFLA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SCFLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/scfla_pkg.sv]
// ============================================================================
// scfla_pkg: shared types and constants of the size-class allocator
// Heap geometry, transaction payload structs, status and operation codes,
// and the size-class helper functions.
// ============================================================================
package scfla_pkg;

  // Heap geometry
  localparam int CLASS_COUNT  = 8;
  localparam int ALIGN_WORDS  = 2;
  localparam int REFILL_WORDS = 4096;
  localparam int HEAP_WORDS   = 65536;

  localparam int WORD_BYTES   = 8;
  localparam int WORD_SHIFT   = 3;
  localparam int ADDR_WORDS   = 65536;
  localparam int USABLE_WORDS = (HEAP_WORDS < ADDR_WORDS) ? HEAP_WORDS : ADDR_WORDS;
  localparam int WASTE_WORDS  = ALIGN_WORDS - 1;
  localparam int MAX_CLASS_BYTES = (CLASS_COUNT * ALIGN_WORDS - 1) * WORD_BYTES;

  // Widths
  localparam int VAL_W   = 20;
  localparam int ADDR_W  = 19;
  localparam int BYTES_W = 16;
  localparam int WORD_W  = $clog2(USABLE_WORDS);
  localparam int CARVE_W = $clog2(USABLE_WORDS) + 1;
  localparam int CLASS_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int STEP_W  = $clog2(CLASS_COUNT * ALIGN_WORDS + 1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_TOO_BIG      = 2'd1,
    ST_NO_MEMORY    = 2'd2,
    ST_FREE_IGNORED = 2'd3
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    status_t           status;
  } rsp_t;

  // Data bytes held by a block of class c (also its header value)
  function automatic logic [VAL_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
    return VAL_W'(((int'(c) + 1) * ALIGN_WORDS - 1) * WORD_BYTES);
  endfunction

  // Words from one block header to the next (header plus data)
  function automatic logic [STEP_W-1:0] step_words(input logic [CLASS_W-1:0] c);
    return STEP_W'((int'(c) + 1) * ALIGN_WORDS);
  endfunction

  // Smallest class that fits nbytes: count of classes that are too small.
  // Only meaningful for nbytes up to MAX_CLASS_BYTES.
  function automatic logic [CLASS_W-1:0] class_of(input logic [VAL_W-1:0] nbytes);
    logic [CLASS_W:0] cnt;
    cnt = '0;
    for (int k = 0; k < CLASS_COUNT; k++) begin
      if (int'(nbytes) > ((k + 1) * ALIGN_WORDS - 1) * WORD_BYTES) begin
        cnt = cnt + 1'b1;
      end
    end
    return cnt[CLASS_W-1:0];
  endfunction

endpackage

[rtl/size_class_free_list_allocator_core.sv]
// ============================================================================
// size_class_free_list_allocator_core: segregated free-list heap allocator
// A pop passes S_POP_RD and S_POP_DONE, a free S_FREE_PUSH, and a reject goes straight to S_DONE.
// A new request is accepted only in S_IDLE, once S_DONE has loaded the previous response.
// A list refill first carves each block in turn through S_CARVE_HDR and S_CARVE_LINK.
// Sync reset empties all lists and the break pointer; heap RAM is not cleared.
// ============================================================================
`include "size_class_free_list_allocator_core_defines.svh"

module size_class_free_list_allocator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  scfla_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output scfla_pkg::rsp_t   rsp
);

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_CARVE_HDR  = 7'b0000010,
    S_CARVE_LINK = 7'b0000100,
    S_POP_RD     = 7'b0001000,
    S_POP_DONE   = 7'b0010000,
    S_FREE_PUSH  = 7'b0100000,
    S_DONE       = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Control and list state
  logic [scfla_pkg::VAL_W-1:0]   heads [scfla_pkg::CLASS_COUNT];
  logic [scfla_pkg::VAL_W-1:0]   brk, brk_next;

  // Per-transaction working registers
  logic [scfla_pkg::CLASS_W-1:0] cls, cls_next;
  logic [scfla_pkg::VAL_W-1:0]   ptr, ptr_next;
  logic [scfla_pkg::CARVE_W-1:0] carve, carve_next;
  logic [scfla_pkg::WORD_W-1:0]  word_idx, word_next;
  logic                          link_zero, link_zero_next;
  scfla_pkg::rsp_t               result, result_next;
  logic                          load_rsp;

  // List head update
  logic                          head_we;
  logic [scfla_pkg::CLASS_W-1:0] head_idx;
  logic [scfla_pkg::VAL_W-1:0]   head_val;

  // Heap RAM ports
  logic [scfla_pkg::VAL_W-1:0]   heap [scfla_pkg::USABLE_WORDS];
  logic                          rd_en, wr_en;
  logic [scfla_pkg::WORD_W-1:0]  rd_addr, wr_addr;
  logic [scfla_pkg::VAL_W-1:0]   rd_data, wr_data;

  // Request decode
  logic [scfla_pkg::CLASS_W-1:0]          req_cls;
  logic [scfla_pkg::VAL_W-1:0]            req_head;
  logic [scfla_pkg::STEP_W-1:0]           req_step;
  logic [scfla_pkg::ADDR_W-4:0]           req_word;
  logic                                   refill_fail;
  logic                                   free_bad;

  // Carve and pop datapath
  logic [scfla_pkg::STEP_W-1:0]           cls_step;
  logic [scfla_pkg::CARVE_W-1:0]          region_start;
  logic [scfla_pkg::CARVE_W:0]            region_end;
  logic [scfla_pkg::CARVE_W-1:0]          next_blk;
  logic                                   carve_more;
  logic [scfla_pkg::VAL_W-1:0]            link;
  logic [scfla_pkg::VAL_W-1:0]            first_blk;
  logic [scfla_pkg::VAL_W-scfla_pkg::WORD_SHIFT-1:0] ptr_word;
  logic                                   ptr_word_ok;
  logic [scfla_pkg::CLASS_W-1:0]          free_cls;

  assign req_ready = (state == S_IDLE);

  // Request-side decode
  assign req_cls  = scfla_pkg::class_of(scfla_pkg::VAL_W'(req.request_bytes));
  assign req_head = heads[req_cls];
  assign req_step = scfla_pkg::step_words(req_cls);
  assign req_word = req.block_address[scfla_pkg::ADDR_W-1:scfla_pkg::WORD_SHIFT];

  assign refill_fail =
      (({1'b0, brk} + (scfla_pkg::VAL_W+1)'(scfla_pkg::REFILL_WORDS)) >
       (scfla_pkg::VAL_W+1)'(scfla_pkg::USABLE_WORDS)) ||
      (32'(req_step) > 32'(scfla_pkg::REFILL_WORDS - scfla_pkg::WASTE_WORDS));

  assign free_bad = (req_word == '0) || (int'(req_word) >= scfla_pkg::USABLE_WORDS);

  // Region carving: blocks laid end to end from the break pointer
  assign cls_step     = scfla_pkg::step_words(cls);
  assign region_start = scfla_pkg::CARVE_W'(brk) + scfla_pkg::CARVE_W'(scfla_pkg::WASTE_WORDS);
  assign region_end   = (scfla_pkg::CARVE_W+1)'(brk) +
                        (scfla_pkg::CARVE_W+1)'(scfla_pkg::REFILL_WORDS);
  assign next_blk     = carve + scfla_pkg::CARVE_W'(cls_step);
  assign carve_more   = ((scfla_pkg::CARVE_W+1)'(carve) +
                         (scfla_pkg::CARVE_W+1)'({cls_step, 1'b0})) <= region_end;
  assign link         = scfla_pkg::VAL_W'({next_blk + 1'b1, {scfla_pkg::WORD_SHIFT{1'b0}}});
  assign first_blk    = scfla_pkg::VAL_W'({region_start + 1'b1,
                                            {scfla_pkg::WORD_SHIFT{1'b0}}});

  // Pop: head pointer as a word index; out-of-heap links read as empty
  assign ptr_word    = ptr[scfla_pkg::VAL_W-1:scfla_pkg::WORD_SHIFT];
  assign ptr_word_ok = int'(ptr_word) < scfla_pkg::USABLE_WORDS;

  // Free: class from the header word just read
  assign free_cls = scfla_pkg::class_of(rd_data);

  // Sequencer
  always_comb begin
    state_next     = state;
    brk_next       = brk;
    cls_next       = cls;
    ptr_next       = ptr;
    carve_next     = carve;
    word_next      = word_idx;
    link_zero_next = link_zero;
    result_next    = result;
    load_rsp       = 1'b0;
    head_we        = 1'b0;
    head_idx       = cls;
    head_val       = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.operation == scfla_pkg::OP_ALLOC) begin
            cls_next = req_cls;
            if (int'(req.request_bytes) > scfla_pkg::MAX_CLASS_BYTES) begin
              result_next = '{granted_address: '0, status: scfla_pkg::ST_TOO_BIG};
              state_next  = S_DONE;
            end else if (req_head != '0) begin
              ptr_next   = req_head;
              state_next = S_POP_RD;
            end else if (refill_fail) begin
              result_next = '{granted_address: '0, status: scfla_pkg::ST_NO_MEMORY};
              state_next  = S_DONE;
            end else begin
              carve_next = region_start;
              state_next = S_CARVE_HDR;
            end
          end else begin
            if (free_bad) begin
              result_next = '{granted_address: '0, status: scfla_pkg::ST_FREE_IGNORED};
              state_next  = S_DONE;
            end else begin
              // fetch the size header in front of the block
              rd_en      = 1'b1;
              rd_addr    = scfla_pkg::WORD_W'(req_word - 1'b1);
              word_next  = scfla_pkg::WORD_W'(req_word);
              state_next = S_FREE_PUSH;
            end
          end
        end
      end

      S_CARVE_HDR: begin
        wr_en      = 1'b1;
        wr_addr    = carve[scfla_pkg::WORD_W-1:0];
        wr_data    = scfla_pkg::class_bytes(cls);
        state_next = S_CARVE_LINK;
      end

      S_CARVE_LINK: begin
        wr_en   = 1'b1;
        wr_addr = scfla_pkg::WORD_W'(carve + 1'b1);
        if (carve_more) begin
          wr_data    = link;
          carve_next = next_blk;
          state_next = S_CARVE_HDR;
        end else begin
          // last block: list ends, region is committed
          wr_data    = '0;
          ptr_next   = first_blk;
          brk_next   = scfla_pkg::VAL_W'({1'b0, brk} +
                                         (scfla_pkg::VAL_W+1)'(scfla_pkg::REFILL_WORDS));
          state_next = S_POP_RD;
        end
      end

      S_POP_RD: begin
        link_zero_next = !ptr_word_ok;
        rd_en          = ptr_word_ok;
        rd_addr        = ptr_word[scfla_pkg::WORD_W-1:0];
        state_next     = S_POP_DONE;
      end

      S_POP_DONE: begin
        head_we     = 1'b1;
        head_idx    = cls;
        head_val    = link_zero ? '0 : rd_data;
        result_next = '{granted_address: ptr[scfla_pkg::ADDR_W-1:0],
                        status: scfla_pkg::ST_OK};
        state_next  = S_DONE;
      end

      S_FREE_PUSH: begin
        if (int'(rd_data) > scfla_pkg::MAX_CLASS_BYTES) begin
          result_next = '{granted_address: '0, status: scfla_pkg::ST_FREE_IGNORED};
        end else begin
          // link block to old head, block becomes new head
          wr_en       = 1'b1;
          wr_addr     = word_idx;
          wr_data     = heads[free_cls];
          head_we     = 1'b1;
          head_idx    = free_cls;
          head_val    = scfla_pkg::VAL_W'({word_idx, {scfla_pkg::WORD_SHIFT{1'b0}}});
          result_next = '{granted_address: '0, status: scfla_pkg::ST_OK};
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      brk       <= '0;
      heads     <= '{default: '0};
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      brk   <= brk_next;
      if (head_we) begin
        heads[head_idx] <= head_val;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    cls       <= cls_next;
    ptr       <= ptr_next;
    carve     <= carve_next;
    word_idx  <= word_next;
    link_zero <= link_zero_next;
    result    <= result_next;
    if (load_rsp) begin
      rsp <= result;
    end
  end

  // Heap RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= heap[rd_addr];
    end
  end

  // Checks
  `SCFLA_ASSERT_ALWAYS(a_brk_in_heap, int'(brk) <= scfla_pkg::USABLE_WORDS, "break pointer past heap")
  `SCFLA_ASSERT_IMPL(a_carve_in_region, state == S_CARVE_HDR, ((scfla_pkg::CARVE_W+1)'(carve) + (scfla_pkg::CARVE_W+1)'(cls_step)) <= region_end, "carved block leaves region")
  `SCFLA_ASSERT_NEXT(a_refill_advance, state == S_CARVE_LINK && !carve_more, (brk - $past(brk)) == scfla_pkg::VAL_W'(scfla_pkg::REFILL_WORDS), "break pointer not advanced by one region")
  `SCFLA_ASSERT_NEXT(a_pop_grant, state == S_POP_DONE, result.status == scfla_pkg::ST_OK && result.granted_address != '0, "pop produced null grant")
  `SCFLA_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state != S_IDLE, "accepted request did not start")

endmodule
